### rtl/vmbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vmbc_pkg
// Shared types and constants of the voxel mask boundary classifier.
// ============================================================================
package vmbc_pkg;

    // Largest row length and row count of one plane
    localparam int MAX_SIZE_I = 256;
    localparam int MAX_SIZE_J = 256;

    // Position and address widths
    localparam int I_W   = (MAX_SIZE_I > 1) ? $clog2(MAX_SIZE_I) : 1;
    localparam int J_W   = (MAX_SIZE_J > 1) ? $clog2(MAX_SIZE_J) : 1;
    localparam int K_W   = 16;
    localparam int Q_W   = ((MAX_SIZE_I * MAX_SIZE_J) > 1) ?
                           $clog2(MAX_SIZE_I * MAX_SIZE_J) : 1;
    localparam int SIZE_IJ_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_I        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_J        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_K        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDING_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_KIND = 3'd4;

    // Item commands
    localparam logic CMD_VOXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Padding modes
    localparam logic [1:0] PAD_ZERO     = 2'd0;
    localparam logic [1:0] PAD_ADAPTIVE = 2'd1;

    // Boundary kinds
    localparam logic KIND_EDGE = 1'b0;

    // Input item
    typedef struct packed {
        logic       command;
        logic [7:0] voxel;
    } vmbc_in_t;

    // Result item
    typedef struct packed {
        logic [5:0] boundary_code;
        logic       last;
    } vmbc_out_t;

    // Window access control for one tick
    typedef struct packed {
        logic           tick;
        logic           wr;
        logic           wflag;
        logic           same_q;
        logic [Q_W-1:0] waddr;
        logic [Q_W-1:0] raddr_a;
        logic [Q_W-1:0] raddr_b;
        logic [I_W-1:0] row_widx;
        logic [I_W-1:0] row_ridx;
    } vmbc_wctl_t;

    // Neighbour flags of the voxel being classified (previous plane)
    typedef struct packed {
        logic center;
        logic below_k;
        logic prev_i;
        logic next_i;
        logic prev_j;
        logic next_j;
    } vmbc_nbr_t;

endpackage
`default_nettype wire

### rtl/voxel_mask_boundary_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// voxel_mask_boundary_classifier_unit
// Six-neighbour boundary classifier for a raster-ordered 3D binary mask.
// ============================================================================
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  item     | item_valid, item_ready, item          | in
//  result   | result_valid, result_ready, result    | out
//  config   | cfg_we, cfg_index, cfg_data           | in
//
//  One item per cycle while item_ready is high. A voxel's result is
//  computed in the cycle the item one plane later or a drain is taken, then queued.
//  Neighbour reads are prefetched from the plane memory one tick ahead.
//  No clearing pass after reset: window entries are written before read.
//  item_ready drops only while the two-entry result queue is full.
// ============================================================================
module voxel_mask_boundary_classifier_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire vmbc_pkg::vmbc_in_t                  item,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output vmbc_pkg::vmbc_out_t                      result,
    input  wire logic                                cfg_we,
    input  wire logic [vmbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [vmbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vmbc_pkg::*;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration registers
    logic [SIZE_IJ_W-1:0] size_i_reg;
    logic [SIZE_IJ_W-1:0] size_j_reg;
    logic [K_W-1:0]       size_k_reg;
    logic [1:0]           padding_mode_reg;
    logic                 boundary_kind_reg;
    logic                 cfg_hit;

    // Stream position of the next tick
    logic [I_W-1:0] ri_reg, ri_next;
    logic [J_W-1:0] rj_reg, rj_next;
    logic [K_W-1:0] rk_reg, rk_next;
    logic [Q_W-1:0] rq_reg, rq_next;

    // Clamped sizes, minus one
    logic [I_W-1:0] ni_m1;
    logic [J_W-1:0] nj_m1;
    logic [K_W-1:0] nk_m1;

    logic accept, is_voxel, rk_full, vox_tick, drain_tick, tick, emit;
    logic i_last, j_last, ia_last;
    logic pad_i, pad_j, pad_k;
    logic [5:0] code;
    vmbc_out_t  res;

    vmbc_wctl_t wctl;
    vmbc_nbr_t  nbr;

    // Result queue
    vmbc_out_t        fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    // Configuration writes
    always_comb
    begin
        case (cfg_index)
            CFG_SIZE_I, CFG_SIZE_J, CFG_SIZE_K, CFG_PADDING_MODE,
            CFG_BOUNDARY_KIND: cfg_hit = cfg_we;
            default:           cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_i_reg        <= SIZE_IJ_W'(1);
            size_j_reg        <= SIZE_IJ_W'(1);
            size_k_reg        <= K_W'(1);
            padding_mode_reg  <= PAD_ADAPTIVE;
            boundary_kind_reg <= KIND_EDGE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIZE_I:        size_i_reg        <= cfg_data[SIZE_IJ_W-1:0];
                CFG_SIZE_J:        size_j_reg        <= cfg_data[SIZE_IJ_W-1:0];
                CFG_SIZE_K:        size_k_reg        <= cfg_data[K_W-1:0];
                CFG_PADDING_MODE:  padding_mode_reg  <= cfg_data[1:0];
                CFG_BOUNDARY_KIND: boundary_kind_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Clamp sizes to their legal range
    always_comb
    begin
        if (size_i_reg == '0)
            ni_m1 = '0;
        else if (32'(size_i_reg) > MAX_SIZE_I)
            ni_m1 = I_W'(MAX_SIZE_I - 1);
        else
            ni_m1 = I_W'(size_i_reg - SIZE_IJ_W'(1));

        if (size_j_reg == '0)
            nj_m1 = '0;
        else if (32'(size_j_reg) > MAX_SIZE_J)
            nj_m1 = J_W'(MAX_SIZE_J - 1);
        else
            nj_m1 = J_W'(size_j_reg - SIZE_IJ_W'(1));

        nk_m1 = (size_k_reg == '0) ? '0 : (size_k_reg - K_W'(1));
    end

    // Padding per axis
    always_comb
    begin
        case (padding_mode_reg)
            PAD_ZERO:
            begin
                pad_i = 1'b1;
                pad_j = 1'b1;
                pad_k = 1'b1;
            end
            PAD_ADAPTIVE:
            begin
                pad_i = (ni_m1 != '0);
                pad_j = (nj_m1 != '0);
                pad_k = (nk_m1 != '0);
            end
            default:
            begin
                pad_i = 1'b0;
                pad_j = 1'b0;
                pad_k = 1'b0;
            end
        endcase
    end

    // Tick qualification
    assign item_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign accept     = item_valid && item_ready;
    assign is_voxel   = (item.command == CMD_VOXEL);
    assign rk_full    = (rk_reg == (nk_m1 + K_W'(1)));
    assign vox_tick   = accept && is_voxel && !rk_full;
    assign drain_tick = accept && !is_voxel && rk_full;
    assign tick       = vox_tick || drain_tick;
    assign emit       = (vox_tick && (rk_reg != '0)) || drain_tick;

    assign i_last = (ri_reg == ni_m1);
    assign j_last = (rj_reg == nj_m1);

    // Classify the voxel one plane behind the stream
    always_comb
    begin
        code = '0;
        if (nbr.center)
        begin
            code[0] = (ri_reg == '0) ? pad_i : !nbr.prev_i;
            code[1] = i_last ? pad_i : !nbr.next_i;
            code[2] = (rj_reg == '0) ? pad_j : !nbr.prev_j;
            code[3] = j_last ? pad_j : !nbr.next_j;
            code[4] = (rk_reg == K_W'(1)) ? pad_k : !nbr.below_k;
            code[5] = rk_full ? pad_k : (item.voxel == '0);
        end
        res.boundary_code = (boundary_kind_reg == KIND_EDGE) ?
                            {5'd0, (code != '0)} : code;
        res.last          = drain_tick && i_last && j_last;
    end

    // Stream position advance
    always_comb
    begin
        ri_next = ri_reg;
        rj_next = rj_reg;
        rk_next = rk_reg;
        rq_next = rq_reg;
        if (cfg_hit || (emit && res.last))
        begin
            ri_next = '0;
            rj_next = '0;
            rk_next = '0;
            rq_next = '0;
        end
        else if (tick)
        begin
            if (i_last)
            begin
                ri_next = '0;
                if (j_last)
                begin
                    rj_next = '0;
                    rk_next = rk_reg + K_W'(1);
                    rq_next = '0;
                end
                else
                begin
                    rj_next = rj_reg + J_W'(1);
                    rq_next = rq_reg + Q_W'(1);
                end
            end
            else
            begin
                ri_next = ri_reg + I_W'(1);
                rq_next = rq_reg + Q_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg <= '0;
            rj_reg <= '0;
            rk_reg <= '0;
            rq_reg <= '0;
        end
        else
        begin
            ri_reg <= ri_next;
            rj_reg <= rj_next;
            rk_reg <= rk_next;
            rq_reg <= rq_next;
        end
    end

    // Prefetch addresses for the next tick
    assign ia_last = (ri_next == ni_m1) && (rj_next == nj_m1);

    always_comb
    begin
        wctl.tick     = tick;
        wctl.wr       = vox_tick;
        wctl.wflag    = (item.voxel != '0);
        wctl.same_q   = (rq_next == rq_reg);
        wctl.waddr    = rq_reg;
        wctl.raddr_a  = ia_last ? '0 : (rq_next + Q_W'(1));
        wctl.raddr_b  = rq_next + Q_W'(ni_m1) + Q_W'(1);
        wctl.row_widx = ri_reg;
        wctl.row_ridx = ri_next;
    end

    vmbc_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (wctl),
        .nbr   (nbr)
    );

    // Result queue
    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result       = fifo_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            fifo_mem_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (emit)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            case ({emit, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // Queue never holds more than its depth
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A drain tick always leaves a result waiting
    a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
        drain_tick |=> result_valid)
        else $error("drain transfer gave no result");

    // The final result restarts the stream
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res.last) |=> (rk_reg == '0) && (rq_reg == '0) && (ri_reg == '0))
        else $error("stream position not cleared after last result");
`endif

endmodule
`default_nettype wire

### rtl/vmbc_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vmbc_window
// Flag window: a plane memory holding the flags of the two latest planes for
// each in-plane position, plus a row memory of center flags. Reads are
// prefetched one tick ahead and forwarded around same-edge writes.
// ============================================================================
module vmbc_window (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire vmbc_pkg::vmbc_wctl_t  ctl,
    output vmbc_pkg::vmbc_nbr_t        nbr
);
    import vmbc_pkg::*;

    localparam int PLANE_DEPTH = 2 ** Q_W;

    // Word: bit 1 newer plane, bit 0 older plane
    logic [1:0] plane_mem [PLANE_DEPTH];
    logic       row_mem   [MAX_SIZE_I];

    logic [1:0] rd_a_reg;
    logic [1:0] rd_b_reg;
    logic       row_rd_reg;

    logic       fwd_a_sel_reg;
    logic       fwd_b_sel_reg;
    logic       row_fwd_sel_reg;
    logic [1:0] fwd_word_reg;
    logic       row_fwd_reg;

    logic [1:0] cur_reg;
    logic       prev_reg;

    logic [1:0] nxt_word;
    logic [1:0] dn_word;
    logic       up_flag;
    logic [1:0] wword;

    // Read data with forwarding applied
    assign nxt_word = fwd_a_sel_reg   ? fwd_word_reg : rd_a_reg;
    assign dn_word  = fwd_b_sel_reg   ? fwd_word_reg : rd_b_reg;
    assign up_flag  = row_fwd_sel_reg ? row_fwd_reg  : row_rd_reg;
    assign wword    = {ctl.wflag, cur_reg[1]};

    // Plane memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            plane_mem[ctl.waddr] <= wword;
        end
        if (ctl.tick)
        begin
            rd_a_reg <= plane_mem[ctl.raddr_a];
            rd_b_reg <= plane_mem[ctl.raddr_b];
        end
    end

    // Row memory of center flags
    always_ff @(posedge clk)
    begin
        if (ctl.tick)
        begin
            row_mem[ctl.row_widx] <= cur_reg[1];
            row_rd_reg            <= row_mem[ctl.row_ridx];
        end
    end

    // Forwarding selects
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_a_sel_reg   <= 1'b0;
            fwd_b_sel_reg   <= 1'b0;
            row_fwd_sel_reg <= 1'b0;
        end
        else if (ctl.tick)
        begin
            fwd_a_sel_reg   <= ctl.wr && (ctl.raddr_a == ctl.waddr);
            fwd_b_sel_reg   <= ctl.wr && (ctl.raddr_b == ctl.waddr);
            row_fwd_sel_reg <= (ctl.row_ridx == ctl.row_widx);
        end
    end

    // Center word and its predecessor; one-voxel planes take the new write
    always_ff @(posedge clk)
    begin
        if (ctl.tick)
        begin
            fwd_word_reg <= wword;
            row_fwd_reg  <= cur_reg[1];
            cur_reg      <= (ctl.wr && ctl.same_q) ? wword : nxt_word;
            prev_reg     <= cur_reg[1];
        end
    end

    assign nbr.center  = cur_reg[1];
    assign nbr.below_k = cur_reg[0];
    assign nbr.prev_i  = prev_reg;
    assign nbr.next_i  = nxt_word[1];
    assign nbr.prev_j  = up_flag;
    assign nbr.next_j  = dn_word[1];

endmodule
`default_nettype wire

### tb/vmbc_boundary_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// vmbc_boundary_checker
// Watches the item, result and config channels of the boundary classifier,
// keeps its own copy of the mask window, stream position and registers, and
// compares every result transfer with the oldest predicted boundary code.
// ============================================================================
module vmbc_boundary_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    input  wire logic                                item_ready,
    input  wire vmbc_pkg::vmbc_in_t                  item,
    input  wire logic                                result_valid,
    input  wire logic                                result_ready,
    input  wire vmbc_pkg::vmbc_out_t                 result,
    input  wire logic                                cfg_we,
    input  wire logic [vmbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [vmbc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                       mismatch_count,
    output int                                       codes_outstanding
);

    import vmbc_pkg::*;

    localparam int WIN_DEPTH  = 2 * MAX_SIZE_I * MAX_SIZE_J + 1;
    localparam int REPORT_MAX = 100;
    localparam longint unsigned MAX_SIZE_K = 65535;

    // Nonzero flags of the received voxels, indexed by raster position
    bit              mask_flags [0:WIN_DEPTH-1];

    // Register copies
    logic [8:0]      cur_size_i;
    logic [8:0]      cur_size_j;
    logic [15:0]     cur_size_k;
    logic [1:0]      cur_pad;
    logic            cur_kind;

    // Stream position: voxels taken and the next voxel to classify
    longint unsigned voxels_seen;
    longint unsigned at_i;
    longint unsigned at_j;
    longint unsigned at_k;

    vmbc_out_t       expected_codes [$];
    vmbc_out_t       want;

    function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned max_v);
        if (v == 0) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    function automatic longint unsigned dim_i();
        return clamp_dim(cur_size_i, MAX_SIZE_I);
    endfunction

    function automatic longint unsigned dim_j();
        return clamp_dim(cur_size_j, MAX_SIZE_J);
    endfunction

    function automatic longint unsigned dim_k();
        return clamp_dim(cur_size_k, MAX_SIZE_K);
    endfunction

    // Whether an edge of an axis of this length counts as zero padded
    function automatic bit axis_padded(longint unsigned len);
        case (cur_pad)
            PAD_ZERO:     return 1'b1;
            PAD_ADAPTIVE: return len > 1;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit flag_at(longint unsigned lin);
        return mask_flags[lin % WIN_DEPTH];
    endfunction

    function automatic longint unsigned next_linear();
        return at_i + dim_i() * (at_j + dim_j() * at_k);
    endfunction

    function automatic void restart_stream();
        voxels_seen = 0;
        at_i = 0;
        at_j = 0;
        at_k = 0;
    endfunction

    // Face code of the next pending voxel; moves the position on
    function automatic vmbc_out_t classify_pending();
        longint unsigned ni;
        longint unsigned nj;
        longint unsigned nk;
        longint unsigned plane;
        longint unsigned p;
        logic [5:0]      code;
        vmbc_out_t       res;
        ni    = dim_i();
        nj    = dim_j();
        nk    = dim_k();
        plane = ni * nj;
        p     = next_linear();
        code  = '0;
        if (flag_at(p)) begin
            if (at_i == 0) begin
                if (axis_padded(ni)) code[0] = 1'b1;
            end else if (!flag_at(p - 1)) code[0] = 1'b1;
            if (at_i == ni - 1) begin
                if (axis_padded(ni)) code[1] = 1'b1;
            end else if (!flag_at(p + 1)) code[1] = 1'b1;
            if (at_j == 0) begin
                if (axis_padded(nj)) code[2] = 1'b1;
            end else if (!flag_at(p - ni)) code[2] = 1'b1;
            if (at_j == nj - 1) begin
                if (axis_padded(nj)) code[3] = 1'b1;
            end else if (!flag_at(p + ni)) code[3] = 1'b1;
            if (at_k == 0) begin
                if (axis_padded(nk)) code[4] = 1'b1;
            end else if (!flag_at(p - plane)) code[4] = 1'b1;
            if (at_k == nk - 1) begin
                if (axis_padded(nk)) code[5] = 1'b1;
            end else if (!flag_at(p + plane)) code[5] = 1'b1;
        end
        // edge mode only tells inside boundary or not
        if (cur_kind == KIND_EDGE) code = {5'b0, |code};
        res.boundary_code = code;
        res.last          = (p + 1 == plane * nk);
        if (res.last) begin
            restart_stream();
        end else begin
            at_i++;
            if (at_i >= ni) begin
                at_i = 0;
                at_j++;
                if (at_j >= nj) begin
                    at_j = 0;
                    at_k++;
                end
            end
        end
        return res;
    endfunction

    // Predict what one item transfer releases
    function automatic void predict_item(vmbc_in_t it);
        longint unsigned plane;
        longint unsigned total;
        longint unsigned p;
        longint unsigned r;
        plane = dim_i() * dim_j();
        total = plane * dim_k();
        p     = next_linear();
        r     = voxels_seen;
        if (it.command == CMD_VOXEL) begin
            // surplus voxels past the end of the volume are dropped
            if (r < total) begin
                mask_flags[r % WIN_DEPTH] = (it.voxel != 8'h00);
                voxels_seen = r + 1;
                if (r == p + plane) expected_codes.push_back(classify_pending());
            end
        end else if (r == total && p < r) begin
            expected_codes.push_back(classify_pending());
        end
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        bit known;
        known = 1'b1;
        case (idx)
            CFG_SIZE_I:        cur_size_i = data[8:0];
            CFG_SIZE_J:        cur_size_j = data[8:0];
            CFG_SIZE_K:        cur_size_k = data[15:0];
            CFG_PADDING_MODE:  cur_pad    = data[1:0];
            CFG_BOUNDARY_KIND: cur_kind   = data[0];
            default:           known      = 1'b0;
        endcase
        // a register write abandons the volume in progress
        if (known) restart_stream();
    endfunction

    function automatic void note_mismatch(string what, int exp_val, int act_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_val, act_val);
    endfunction

    // Result compare first, then register writes, then item prediction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int n = 0; n < WIN_DEPTH; n++) mask_flags[n] = 1'b0;
            cur_size_i = 9'd1;
            cur_size_j = 9'd1;
            cur_size_k = 16'd1;
            cur_pad    = PAD_ADAPTIVE;
            cur_kind   = KIND_EDGE;
            restart_stream();
            expected_codes.delete();
            mismatch_count    = 0;
            codes_outstanding = 0;
        end else begin
            if (result_valid && result_ready) begin
                if (expected_codes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected result: expected none, actual code %0d last %0d",
                                 $time, result.boundary_code, result.last);
                end else begin
                    want = expected_codes.pop_front();
                    if (result.boundary_code !== want.boundary_code)
                        note_mismatch("boundary_code", want.boundary_code, result.boundary_code);
                    if (result.last !== want.last)
                        note_mismatch("last", want.last, result.last);
                end
            end
            if (cfg_we) apply_config(cfg_index, cfg_data);
            if (item_valid && item_ready) predict_item(item);
            codes_outstanding = expected_codes.size();
        end
    end

endmodule

### tb/tb_voxel_mask_boundary_classifier_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_voxel_mask_boundary_classifier_unit
// Drives mask volumes through the boundary classifier under several register
// settings: a short directed part, extreme sizes with a long result stall,
// then random volumes, well formed and broken. The checker predicts and
// compares; this module makes stimulus and gives the verdict.
// ============================================================================
module tb_voxel_mask_boundary_classifier_unit;

    import vmbc_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 5;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     ITEM_TARGET   = 850;
    localparam longint CYCLE_LIMIT   = 2_000_000;

    // Codes used only here
    localparam logic [1:0]           PAD_NONE  = 2'd2;
    localparam logic [1:0]           PAD_ODD   = 2'd3;
    localparam logic                 KIND_FACE = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

    // Directed mask bytes, first voxel in the top byte
    localparam logic [63:0] DIRECTED_MASK = 64'hFF01_8000_7FFF_0010;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    vmbc_in_t              item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    vmbc_out_t             result;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int     mismatch_count;
    int     codes_outstanding;
    int     size_i_now = 1;
    int     size_j_now = 1;
    int     size_k_now = 1;
    int     items_sent = 0;
    bit     squeeze_req  = 1'b0;
    bit     squeeze_done = 1'b0;
    longint cycle_count  = 0;

    voxel_mask_boundary_classifier_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    vmbc_boundary_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .item              (item),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .result            (result),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatch_count),
        .codes_outstanding (codes_outstanding)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_voxel();
        if ($urandom_range(0, 99) < 40) return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic int clamp_dim(int v, int max_v);
        if (v == 0) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    // One item transfer, after a random gap; valid holds until taken
    task automatic send_item(input logic cmd, input logic [7:0] vox);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= {cmd, vox};
        do @(posedge clk); while (!item_ready);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SIZE_I: size_i_now = int'(data[8:0]);
            CFG_SIZE_J: size_j_now = int'(data[8:0]);
            CFG_SIZE_K: size_k_now = int'(data);
            default: ;
        endcase
    endtask

    task automatic cfg_all(input logic [15:0] si, input logic [15:0] sj, input logic [15:0] sk,
                           input logic [15:0] pad, input logic [15:0] kind);
        cfg_write(CFG_SIZE_I, si);
        cfg_write(CFG_SIZE_J, sj);
        cfg_write(CFG_SIZE_K, sk);
        cfg_write(CFG_PADDING_MODE, pad);
        cfg_write(CFG_BOUNDARY_KIND, kind);
    endtask

    // Stop offering, wait out every expected result and the pipeline
    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (codes_outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Whole volume, then one drain per voxel of the last plane
    task automatic stream_volume(input bit noisy, input int squeeze_after);
        int plane;
        int total;
        plane = clamp_dim(size_i_now, MAX_SIZE_I) * clamp_dim(size_j_now, MAX_SIZE_J);
        total = plane * clamp_dim(size_k_now, 65535);
        for (int v = 0; v < total; v++) begin
            if (noisy && $urandom_range(0, 11) == 0) send_item(CMD_DRAIN, 8'($urandom));
            send_item(CMD_VOXEL, pick_voxel());
            if (v == squeeze_after) squeeze_req = 1'b1;
        end
        // surplus voxels before the drains are ignored
        if (noisy) repeat ($urandom_range(0, 2)) send_item(CMD_VOXEL, pick_voxel());
        for (int d = 0; d < plane; d++) begin
            if (noisy && $urandom_range(0, 14) == 0) send_item(CMD_VOXEL, pick_voxel());
            send_item(CMD_DRAIN, 8'($urandom));
        end
        if (noisy) repeat ($urandom_range(0, 1)) send_item(CMD_DRAIN, 8'($urandom));
    endtask

    // First plane and a few voxels of the next, left for the next write to abandon
    task automatic partial_volume(input int extra, input int squeeze_after);
        int plane;
        plane = clamp_dim(size_i_now, MAX_SIZE_I) * clamp_dim(size_j_now, MAX_SIZE_J);
        for (int v = 0; v < plane + extra; v++) begin
            send_item(CMD_VOXEL, pick_voxel());
            if (v == squeeze_after) squeeze_req = 1'b1;
        end
    endtask

    // Partial volume with stray drains, left for the next write to abandon
    task automatic broken_volume();
        int total;
        int count;
        total = clamp_dim(size_i_now, MAX_SIZE_I) * clamp_dim(size_j_now, MAX_SIZE_J) *
                clamp_dim(size_k_now, 65535);
        count = $urandom_range(0, total);
        for (int v = 0; v < count; v++) begin
            if ($urandom_range(0, 9) < 3) send_item(CMD_DRAIN, 8'($urandom));
            send_item(CMD_VOXEL, pick_voxel());
        end
    endtask

    task automatic random_phase();
        int         r;
        logic [8:0] si;
        logic [8:0] sj;
        logic [15:0] sk;
        r  = $urandom_range(0, 99);
        si = (r < 70) ? 9'($urandom_range(1, 6)) : (r < 92) ? 9'($urandom_range(7, 24)) : 9'd0;
        r  = $urandom_range(0, 99);
        sj = (r < 75) ? 9'($urandom_range(1, 4)) : (r < 92) ? 9'($urandom_range(5, 8)) : 9'd0;
        r  = $urandom_range(0, 99);
        sk = (r < 80) ? 16'($urandom_range(1, 4)) : (r < 92) ? 16'($urandom_range(5, 6)) : 16'd0;
        // size_i always written so a broken volume is always abandoned
        cfg_write(CFG_SIZE_I, {7'($urandom), si});
        if ($urandom_range(0, 3) != 0) cfg_write(CFG_SIZE_J, {7'($urandom), sj});
        if ($urandom_range(0, 3) != 0) cfg_write(CFG_SIZE_K, sk);
        if ($urandom_range(0, 3) != 0) cfg_write(CFG_PADDING_MODE, 16'($urandom));
        if ($urandom_range(0, 3) != 0) cfg_write(CFG_BOUNDARY_KIND, 16'($urandom));
        if ($urandom_range(0, 3) != 0) stream_volume(1'b1, -1);
        else broken_volume();
        wait_idle();
    endtask

    // Result side: random ready with one long hold-off on request
    initial begin : result_side
        int on_len;
        int off_len;
        @(posedge rst_n);
        forever begin
            if (squeeze_req && !squeeze_done) begin
                squeeze_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge clk);
                    result_ready <= 1'b0;
                end
            end else begin
                on_len = $urandom_range(1, 24);
                repeat (on_len) begin
                    @(negedge clk);
                    result_ready <= 1'b1;
                end
                off_len = pick_gap();
                repeat (off_len) begin
                    @(negedge clk);
                    result_ready <= 1'b0;
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, single voxel volume: early drain, surplus voxel,
        // the last result, then a drain with nothing pending
        send_item(CMD_DRAIN, 8'hA5);
        send_item(CMD_VOXEL, 8'hFF);
        send_item(CMD_VOXEL, 8'h00);
        send_item(CMD_DRAIN, 8'h5A);
        send_item(CMD_DRAIN, 8'h00);
        wait_idle();

        // 2x2x2 face codes under zero padding
        cfg_all(16'd2, 16'd2, 16'd2, {14'd0, PAD_ZERO}, {15'd0, KIND_FACE});
        for (int n = 0; n < 8; n++) send_item(CMD_VOXEL, DIRECTED_MASK[63-8*n -: 8]);
        repeat (4) send_item(CMD_DRAIN, 8'hFF);
        wait_idle();

        // A write to an unused index keeps the volume in progress
        cfg_all(16'd2, 16'd1, 16'd2, {14'd0, PAD_ADAPTIVE}, {15'd0, KIND_EDGE});
        send_item(CMD_VOXEL, 8'hFF);
        send_item(CMD_VOXEL, 8'h00);
        wait_idle();
        cfg_write(CFG_SPARE, 16'hFFFF);
        send_item(CMD_VOXEL, 8'h01);
        send_item(CMD_VOXEL, 8'hFF);
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_DRAIN, 8'h00);
        wait_idle();

        // Longest rows (clamped), long result stall as the second plane starts
        cfg_all(16'hFFFF, 16'd1, 16'd2, {14'h3FFF, PAD_ADAPTIVE}, 16'hFFFF);
        partial_volume(24, 200);
        wait_idle();

        // Most rows per plane (clamped), zero row length, unknown padding mode
        cfg_all(16'd0, 16'd300, 16'd2, {14'd0, PAD_ODD}, {15'd0, KIND_EDGE});
        partial_volume(24, -1);
        wait_idle();

        // Deepest volume, started and abandoned
        cfg_all(16'd1, 16'd1, 16'hFFFF, {14'd0, PAD_ZERO}, {15'd0, KIND_FACE});
        repeat (40) send_item(CMD_VOXEL, pick_voxel());
        wait_idle();

        // A 1x8x3 stripe without padding
        cfg_all(16'd1, 16'd8, 16'd3, {14'd0, PAD_NONE}, {15'd0, KIND_FACE});
        stream_volume(1'b1, -1);
        wait_idle();

        // Random volumes up to the item budget
        while (items_sent < ITEM_TARGET) random_phase();

        wait_idle();
        if (mismatch_count == 0 && codes_outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### voxel_mask_boundary_classifier_unit.f
rtl/vmbc_pkg.sv
rtl/vmbc_window.sv
rtl/voxel_mask_boundary_classifier_unit.sv
tb/vmbc_boundary_checker.sv
tb/tb_voxel_mask_boundary_classifier_unit.sv
